// ----- hw/rtl/assert_macros.svh -----
// concurrent assertion helpers, clocked on clk with rst_n as disable
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_SAME(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/bstu_pkg.sv -----
package bstu_pkg;

    localparam int SLOT_W     = 10;
    localparam int DOM_W      = 3;
    localparam int ADDR_W     = SLOT_W + DOM_W;
    localparam int DEPTH      = 1 << ADDR_W;
    localparam int Q_W        = 16;
    localparam int IN_W       = 17;
    localparam int K_W        = 12;
    localparam int KQ_W       = K_W + 12;
    localparam int N_W        = 35;
    localparam int SUM_W      = 36;
    localparam int NUM_W      = 52;
    localparam int ENTRY_W    = 2 * Q_W + 1;
    localparam int CNT_W      = 6;
    localparam int WIDE_STEPS   = 35;
    localparam int NARROW_STEPS = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [Q_W-1:0]  CONF_CLAMP = 16'd65470;
    localparam logic [IN_W-1:0] ONE_Q16    = 17'd65536;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PRIOR      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_K_DEFAULT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_K_ALGO     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_K_SKILL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_K_RULE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_K_HYPO     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_K_PRED     = 3'd6;

    localparam logic [DOM_W-1:0] DOM_ALGO  = 3'd1;
    localparam logic [DOM_W-1:0] DOM_SKILL = 3'd2;
    localparam logic [DOM_W-1:0] DOM_RULE  = 3'd3;
    localparam logic [DOM_W-1:0] DOM_HYPO  = 3'd4;
    localparam logic [DOM_W-1:0] DOM_PRED  = 3'd5;

    typedef struct packed {
        logic             start;
        logic             wide;
        logic [NUM_W-1:0] num;
        logic [SUM_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [N_W-1:0] quo;
    } div_rsp_t;

endpackage

// ----- hw/rtl/beta_score_table_update.sv -----
// a read (weight zero) gives its result after the table lookup alone, an update
// after the multiply and divide steps as well; busy stays high until the result strobe
// throughput: one item at a time, set by the shared one-bit-per-cycle divider
// (35 + 17 + 17 steps) and the five sequential multiply steps
// reset: asynchronous, active low; registers take their reset values, then a
// clearing pass over all 8192 entries empties the score table, busy high meanwhile
module beta_score_table_update (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [bstu_pkg::SLOT_W-1:0]      subject_slot,
    input  logic [bstu_pkg::DOM_W-1:0]       domain,
    input  logic [bstu_pkg::IN_W-1:0]        outcome,
    input  logic [bstu_pkg::IN_W-1:0]        weight,
    output logic                             result_valid,
    output logic [bstu_pkg::Q_W-1:0]         mean,
    output logic [bstu_pkg::Q_W-1:0]         confidence,
    output logic                             created,
    output logic                             updated,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bstu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bstu_pkg::CFG_DATA_W-1:0]  cfg_data
);

`include "assert_macros.svh"

    // sequencer codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLEAR = 4'd1;
    localparam logic [3:0] S_LOOK  = 4'd2;
    localparam logic [3:0] S_MKC   = 4'd3;
    localparam logic [3:0] S_DN_GO = 4'd4;
    localparam logic [3:0] S_DN_W  = 4'd5;
    localparam logic [3:0] S_MA1   = 4'd6;
    localparam logic [3:0] S_MA2   = 4'd7;
    localparam logic [3:0] S_MB1   = 4'd8;
    localparam logic [3:0] S_MB2   = 4'd9;
    localparam logic [3:0] S_DM_GO = 4'd10;
    localparam logic [3:0] S_DM_W  = 4'd11;
    localparam logic [3:0] S_DC_GO = 4'd12;
    localparam logic [3:0] S_DC_W  = 4'd13;

    localparam logic [bstu_pkg::NUM_W-1:0] HALF_Q32 = bstu_pkg::NUM_W'(64'h8000_0000);

    // configuration registers
    logic [bstu_pkg::Q_W-1:0] prior_reg;
    logic [bstu_pkg::K_W-1:0] k_def_reg, k_algo_reg, k_skill_reg;
    logic [bstu_pkg::K_W-1:0] k_rule_reg, k_hypo_reg, k_pred_reg;

    logic [3:0]                     state_reg, state_next;
    logic [bstu_pkg::ADDR_W-1:0]    clr_reg;
    logic                           accept;
    logic                           div_wait;

    // item context
    logic [bstu_pkg::ADDR_W-1:0]    addr_reg;
    logic [bstu_pkg::IN_W-1:0]      o_reg, w_reg;
    logic [bstu_pkg::KQ_W-1:0]      kq_reg;
    logic [bstu_pkg::K_W-1:0]       k_sel;
    logic [bstu_pkg::Q_W-1:0]       m_reg, cc_reg;
    logic                           exists_reg;

    // arithmetic
    logic [bstu_pkg::IN_W-1:0]      mul_a;
    logic [bstu_pkg::N_W-1:0]       mul_b;
    logic [bstu_pkg::NUM_W-1:0]     prod;
    logic [bstu_pkg::NUM_W-1:0]     acc_reg;
    logic [bstu_pkg::N_W-1:0]       n_reg, alpha_reg, beta;
    logic [bstu_pkg::N_W-1:0]       n2;
    logic [bstu_pkg::SUM_W-1:0]     den_mean, den_conf;
    logic [bstu_pkg::Q_W-1:0]       mean_q_reg, quo_sat;

    // table
    logic                           ram_we;
    logic [bstu_pkg::ADDR_W-1:0]    ram_waddr;
    logic [bstu_pkg::ENTRY_W-1:0]   ram_wdata, ram_rdata;
    logic                           ent_valid;
    logic [bstu_pkg::Q_W-1:0]       ent_mean, ent_conf, look_m, look_c;

    bstu_pkg::div_req_t             dreq;
    bstu_pkg::div_rsp_t             drsp;

    // outputs
    logic                           rv_reg;
    logic [bstu_pkg::Q_W-1:0]       mean_reg, conf_reg;
    logic                           created_reg, updated_reg;

    assign accept    = start && !busy;
    assign busy      = state_reg != S_IDLE;
    assign cfg_ready = 1'b1;
    assign div_wait  = (state_reg == S_DN_W) || (state_reg == S_DM_W)
                    || (state_reg == S_DC_W);

    // kappa chosen from the full domain code
    always_comb
    begin
        unique case (domain)
            bstu_pkg::DOM_ALGO:  k_sel = k_algo_reg;
            bstu_pkg::DOM_SKILL: k_sel = k_skill_reg;
            bstu_pkg::DOM_RULE:  k_sel = k_rule_reg;
            bstu_pkg::DOM_HYPO:  k_sel = k_hypo_reg;
            bstu_pkg::DOM_PRED:  k_sel = k_pred_reg;
            default:             k_sel = k_def_reg;
        endcase
    end

    // config writes; undefined indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_reg   <= 16'd32768;
            k_def_reg   <= 12'd160;
            k_algo_reg  <= 12'd128;
            k_skill_reg <= 12'd192;
            k_rule_reg  <= 12'd320;
            k_hypo_reg  <= 12'd96;
            k_pred_reg  <= 12'd160;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bstu_pkg::REG_PRIOR:     prior_reg   <= cfg_data;
                bstu_pkg::REG_K_DEFAULT: k_def_reg   <= cfg_data[bstu_pkg::K_W-1:0];
                bstu_pkg::REG_K_ALGO:    k_algo_reg  <= cfg_data[bstu_pkg::K_W-1:0];
                bstu_pkg::REG_K_SKILL:   k_skill_reg <= cfg_data[bstu_pkg::K_W-1:0];
                bstu_pkg::REG_K_RULE:    k_rule_reg  <= cfg_data[bstu_pkg::K_W-1:0];
                bstu_pkg::REG_K_HYPO:    k_hypo_reg  <= cfg_data[bstu_pkg::K_W-1:0];
                bstu_pkg::REG_K_PRED:    k_pred_reg  <= cfg_data[bstu_pkg::K_W-1:0];
                default:                 ;
            endcase
        end
    end

    // table entry: {valid, confidence, mean}
    bstu_ram #(
        .WIDTH (bstu_pkg::ENTRY_W),
        .DEPTH (bstu_pkg::DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr ({subject_slot, domain}),
        .rdata (ram_rdata)
    );

    assign ent_valid = ram_rdata[bstu_pkg::ENTRY_W-1];
    assign ent_conf  = ram_rdata[2*bstu_pkg::Q_W-1:bstu_pkg::Q_W];
    assign ent_mean  = ram_rdata[bstu_pkg::Q_W-1:0];
    // a missing entry starts at the prior with zero confidence
    assign look_m    = ent_valid ? ent_mean : prior_reg;
    assign look_c    = ent_valid ? ent_conf : '0;

    assign quo_sat = drsp.quo[bstu_pkg::Q_W] ? {bstu_pkg::Q_W{1'b1}}
                                             : drsp.quo[bstu_pkg::Q_W-1:0];

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = {1'b1, quo_sat, mean_q_reg};
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end
        else if (state_reg == S_DC_W && drsp.done)
        begin
            ram_we = 1'b1;
        end
    end

    // shared multiplier, one product per step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MKC:
            begin
                mul_a = bstu_pkg::IN_W'(cc_reg);
                mul_b = bstu_pkg::N_W'(kq_reg);
            end
            S_MA1:
            begin
                mul_a = bstu_pkg::IN_W'(m_reg);
                mul_b = n_reg;
            end
            S_MA2:
            begin
                mul_a = o_reg;
                mul_b = bstu_pkg::N_W'(w_reg);
            end
            S_MB1:
            begin
                mul_a = bstu_pkg::ONE_Q16 - bstu_pkg::IN_W'(m_reg);
                mul_b = n_reg;
            end
            S_MB2:
            begin
                mul_a = bstu_pkg::ONE_Q16 - o_reg;
                mul_b = bstu_pkg::N_W'(w_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = bstu_pkg::NUM_W'(mul_a) * bstu_pkg::NUM_W'(mul_b);
    end

    // divider operands
    assign beta     = acc_reg[bstu_pkg::N_W+15:16];
    assign den_mean = bstu_pkg::SUM_W'(alpha_reg) + bstu_pkg::SUM_W'(beta);
    assign n2       = n_reg + bstu_pkg::N_W'(w_reg);
    assign den_conf = bstu_pkg::SUM_W'(n2) + bstu_pkg::SUM_W'(kq_reg);

    always_comb
    begin
        dreq.start = 1'b0;
        dreq.wide  = 1'b0;
        dreq.num   = acc_reg;
        dreq.den   = bstu_pkg::SUM_W'(bstu_pkg::ONE_Q16 - bstu_pkg::IN_W'(cc_reg));
        unique case (state_reg)
            S_DN_GO:
            begin
                dreq.start = 1'b1;
                dreq.wide  = 1'b1;
            end
            S_DM_GO:
            begin
                // round half up: add half the divisor
                dreq.start = 1'b1;
                dreq.num   = {1'b0, alpha_reg, 16'b0}
                           + bstu_pkg::NUM_W'(den_mean[bstu_pkg::SUM_W-1:1]);
                dreq.den   = den_mean;
            end
            S_DC_GO:
            begin
                dreq.start = 1'b1;
                dreq.num   = {1'b0, n2, 16'b0}
                           + bstu_pkg::NUM_W'(den_conf[bstu_pkg::SUM_W-1:1]);
                dreq.den   = den_conf;
            end
            default:
            begin
                dreq.start = 1'b0;
            end
        endcase
    end

    bstu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start) state_next = S_LOOK;
            S_CLEAR: if (&clr_reg) state_next = S_IDLE;
            S_LOOK:  state_next = (w_reg == '0) ? S_IDLE : S_MKC;
            S_MKC:   state_next = S_DN_GO;
            S_DN_GO: state_next = S_DN_W;
            S_DN_W:  if (drsp.done) state_next = S_MA1;
            S_MA1:   state_next = S_MA2;
            S_MA2:   state_next = S_MB1;
            S_MB1:   state_next = S_MB2;
            S_MB2:   state_next = S_DM_GO;
            S_DM_GO: state_next = S_DM_W;
            S_DM_W:  if (drsp.done) state_next = S_DC_GO;
            S_DC_GO: state_next = S_DC_W;
            S_DC_W:  if (drsp.done) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            rv_reg <= (state_reg == S_LOOK && w_reg == '0)
                   || (state_reg == S_DC_W && drsp.done);
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg <= {subject_slot, domain};
            o_reg    <= (outcome > bstu_pkg::ONE_Q16) ? bstu_pkg::ONE_Q16 : outcome;
            w_reg    <= (weight > bstu_pkg::ONE_Q16) ? bstu_pkg::ONE_Q16 : weight;
            kq_reg   <= {k_sel, 12'b0};
        end
        if (state_reg == S_LOOK)
        begin
            exists_reg <= ent_valid;
            m_reg      <= look_m;
            cc_reg     <= (look_c > bstu_pkg::CONF_CLAMP) ? bstu_pkg::CONF_CLAMP : look_c;
            mean_reg   <= look_m;
            conf_reg   <= look_c;
            created_reg <= 1'b0;
            updated_reg <= 1'b0;
        end
        unique case (state_reg)
            S_MKC: acc_reg <= prod;
            S_MA1: acc_reg <= prod + HALF_Q32;
            S_MA2: acc_reg <= acc_reg + prod;
            S_MB1:
            begin
                alpha_reg <= acc_reg[bstu_pkg::N_W+15:16];
                acc_reg   <= prod + HALF_Q32;
            end
            S_MB2: acc_reg <= acc_reg + prod;
            default: ;
        endcase
        if (state_reg == S_DN_W && drsp.done)
        begin
            n_reg <= drsp.quo;
        end
        if (state_reg == S_DM_W && drsp.done)
        begin
            mean_q_reg <= quo_sat;
        end
        if (state_reg == S_DC_W && drsp.done)
        begin
            mean_reg    <= mean_q_reg;
            conf_reg    <= quo_sat;
            created_reg <= !exists_reg;
            updated_reg <= 1'b1;
        end
    end

    assign result_valid = rv_reg;
    assign mean         = mean_reg;
    assign confidence   = conf_reg;
    assign created      = created_reg;
    assign updated      = updated_reg;

    `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `ASSERT_SAME(a_result_idle, result_valid, !busy, "result strobe while still busy")
    `ASSERT_SAME(a_read_no_create, result_valid && !updated, !created, "read marked as created")
    `ASSERT_SAME(a_div_done_wait, drsp.done, div_wait, "divider finished outside a wait step")

endmodule

// ----- hw/rtl/bstu_ram.sv -----
module bstu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/bstu_div.sv -----
// restoring divider, one quotient bit per cycle
module bstu_div (
    input  logic               clk,
    input  logic               rst_n,
    input  bstu_pkg::div_req_t req,
    output bstu_pkg::div_rsp_t rsp
);

    logic [bstu_pkg::SUM_W-1:0] rem_reg, rem_next;
    logic [bstu_pkg::NUM_W-1:0] sh_reg, sh_next;
    logic [bstu_pkg::SUM_W-1:0] den_reg;
    logic [bstu_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       run_reg, run_next;
    logic                       done_reg, done_next;
    logic [bstu_pkg::SUM_W:0]   trial;
    logic                       ge;

    always_comb
    begin
        trial = {rem_reg, sh_reg[bstu_pkg::NUM_W-1]};
        ge    = trial >= {1'b0, den_reg};
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            // upper bits go straight to the remainder, they stay below the divisor
            if (req.wide)
            begin
                rem_next = bstu_pkg::SUM_W'(req.num[bstu_pkg::NUM_W-1:bstu_pkg::WIDE_STEPS]);
                sh_next  = {req.num[bstu_pkg::WIDE_STEPS-1:0],
                            {(bstu_pkg::NUM_W-bstu_pkg::WIDE_STEPS){1'b0}}};
                cnt_next = bstu_pkg::CNT_W'(bstu_pkg::WIDE_STEPS);
            end
            else
            begin
                rem_next = bstu_pkg::SUM_W'(req.num[bstu_pkg::NUM_W-1:bstu_pkg::NARROW_STEPS]);
                sh_next  = {req.num[bstu_pkg::NARROW_STEPS-1:0],
                            {(bstu_pkg::NUM_W-bstu_pkg::NARROW_STEPS){1'b0}}};
                cnt_next = bstu_pkg::CNT_W'(bstu_pkg::NARROW_STEPS);
            end
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = ge ? bstu_pkg::SUM_W'(trial - {1'b0, den_reg})
                          : trial[bstu_pkg::SUM_W-1:0];
            sh_next  = {sh_reg[bstu_pkg::NUM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == bstu_pkg::CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        if (req.start)
        begin
            den_reg <= req.den;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = sh_reg[bstu_pkg::N_W-1:0];

endmodule
